>>> sv/ttce_pkg.sv
// shared types and constants of the terminal text cursor engine
package ttce_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    localparam byte_t CH_NUL       = 8'd0;
    localparam byte_t CH_BACKSPACE = 8'd8;
    localparam byte_t CH_LINEFEED  = 8'd10;
    localparam byte_t CH_FORMFEED  = 8'd12;
    localparam byte_t CH_RETURN    = 8'd13;
    localparam byte_t CH_IGNORE_HI = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLS = 8'd1;

    localparam byte_t SCREEN_ROWS_RESET = 8'd25;
    localparam byte_t SCREEN_COLS_RESET = 8'd80;

    typedef struct packed {
        logic  write_cell;
        byte_t cell_char;
        byte_t cell_row;
        byte_t cell_col;
        logic  scroll_up;
        logic  clear_screen;
        byte_t new_cursor_row;
        byte_t new_cursor_col;
    } result_t;

    typedef struct packed {
        logic  emit;
        byte_t cursor_row;
        byte_t cursor_col;
    } step_t;

endpackage

>>> sv/ttce_cursor_logic.sv
// next-cursor and cell-write decode for one received byte
module ttce_cursor_logic (
    input  ttce_pkg::byte_t   rx_byte,
    input  ttce_pkg::byte_t   cursor_row,
    input  ttce_pkg::byte_t   cursor_col,
    input  ttce_pkg::byte_t   screen_rows,
    input  ttce_pkg::byte_t   screen_cols,
    output ttce_pkg::step_t   step,
    output ttce_pkg::result_t result
);
    import ttce_pkg::*;

    byte_t last_row;
    byte_t last_col;
    byte_t row_sat;
    byte_t col_sat;
    byte_t row;
    byte_t col;

    assign last_row = (screen_rows == 8'd0) ? 8'd0 : screen_rows - 8'd1;
    assign last_col = (screen_cols == 8'd0) ? 8'd0 : screen_cols - 8'd1;
    assign row_sat  = (cursor_row > last_row) ? last_row : cursor_row;
    assign col_sat  = (cursor_col > last_col) ? last_col : cursor_col;

    always_comb
    begin
        row    = row_sat;
        col    = col_sat;
        result = '0;
        priority if (rx_byte == CH_FORMFEED)
        begin
            result.clear_screen = 1'b1;
            row = 8'd0;
            col = 8'd0;
        end
        else if (rx_byte == CH_BACKSPACE)
        begin
            if (col_sat != 8'd0)
                col = col_sat - 8'd1;
        end
        else if (rx_byte == CH_RETURN)
        begin
            col = 8'd0;
        end
        else if (rx_byte == CH_LINEFEED)
        begin
            if (row_sat == last_row)
                result.scroll_up = 1'b1;
            else
                row = row_sat + 8'd1;
        end
        else
        begin
            result.write_cell = 1'b1;
            result.cell_char  = rx_byte;
            result.cell_row   = row_sat;
            result.cell_col   = col_sat;
            if (col_sat == last_col)
            begin
                col = 8'd0;
                if (row_sat == last_row)
                    result.scroll_up = 1'b1;
                else
                    row = row_sat + 8'd1;
            end
            else
            begin
                col = col_sat + 8'd1;
            end
        end
        result.new_cursor_row = row;
        result.new_cursor_col = col;
    end

    // ignored bytes still keep the saturated cursor
    assign step.emit       = (rx_byte != CH_NUL) && (rx_byte != CH_IGNORE_HI);
    assign step.cursor_row = step.emit ? row : row_sat;
    assign step.cursor_col = step.emit ? col : col_sat;

endmodule

>>> sv/terminal_text_cursor_engine.sv
// top level of the terminal text cursor engine
// a result is registered and valid in the cycle after its byte is accepted
// throughput: one byte per cycle while in_stall is low, set by the cursor register feedback loop
// a waiting result in the output register blocks input only while out_stall is high
// reset (rst_n low, asynchronous) homes the cursor, loads 25 rows by 80 columns
// and empties the output register
module terminal_text_cursor_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ttce_pkg::byte_t                     rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_cell,
    output ttce_pkg::byte_t                     cell_char,
    output ttce_pkg::byte_t                     cell_row,
    output ttce_pkg::byte_t                     cell_col,
    output logic                                scroll_up,
    output logic                                clear_screen,
    output ttce_pkg::byte_t                     new_cursor_row,
    output ttce_pkg::byte_t                     new_cursor_col,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  ttce_pkg::byte_t                     cfg_data
);
    import ttce_pkg::*;

    byte_t   screen_rows_reg;
    byte_t   screen_cols_reg;
    byte_t   cursor_row_reg;
    byte_t   cursor_col_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;
    step_t   step;
    logic    in_xfer;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;

    ttce_cursor_logic u_cursor_logic (
        .rx_byte     (rx_byte),
        .cursor_row  (cursor_row_reg),
        .cursor_col  (cursor_col_reg),
        .screen_rows (screen_rows_reg),
        .screen_cols (screen_cols_reg),
        .step        (step),
        .result      (result_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (in_xfer)
            out_valid_next = step.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg <= SCREEN_ROWS_RESET;
            screen_cols_reg <= SCREEN_COLS_RESET;
            cursor_row_reg  <= 8'd0;
            cursor_col_reg  <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SCREEN_ROWS)
                    screen_rows_reg <= cfg_data;
                else if (cfg_index == REG_SCREEN_COLS)
                    screen_cols_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                cursor_row_reg <= step.cursor_row;
                cursor_col_reg <= step.cursor_col;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && step.emit)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign write_cell     = result_reg.write_cell;
    assign cell_char      = result_reg.cell_char;
    assign cell_row       = result_reg.cell_row;
    assign cell_col       = result_reg.cell_col;
    assign scroll_up      = result_reg.scroll_up;
    assign clear_screen   = result_reg.clear_screen;
    assign new_cursor_row = result_reg.new_cursor_row;
    assign new_cursor_col = result_reg.new_cursor_col;

endmodule

>>> sv/ttce_checker.sv
// port-level assertions for the terminal text cursor engine and their bind
module ttce_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input ttce_pkg::byte_t rx_byte,
    input logic            out_valid,
    input logic            out_stall,
    input logic            write_cell,
    input ttce_pkg::byte_t cell_char,
    input ttce_pkg::byte_t cell_row,
    input ttce_pkg::byte_t cell_col,
    input logic            scroll_up,
    input logic            clear_screen,
    input ttce_pkg::byte_t new_cursor_row,
    input ttce_pkg::byte_t new_cursor_col
);
    import ttce_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_cursor_row)
            && $stable(new_cursor_col) && $stable(write_cell) && $stable(cell_char))
        else $error("stalled result changed");

    // ignored byte transfer gives no result
    a_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (rx_byte == CH_NUL || rx_byte == CH_IGNORE_HI)
            |=> !out_valid)
        else $error("ignored byte produced a result");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_cell |-> cell_char == 8'd0 && cell_row == 8'd0
            && cell_col == 8'd0)
        else $error("cell fields set without a write");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clear_screen |-> !write_cell && !scroll_up
            && new_cursor_row == 8'd0 && new_cursor_col == 8'd0)
        else $error("clear did not home the cursor");

    // a write without wrap advances one column on the same row
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_cell && new_cursor_col != 8'd0
            |-> new_cursor_col == cell_col + 8'd1 && new_cursor_row == cell_row && !scroll_up)
        else $error("write did not advance the cursor");

endmodule

bind terminal_text_cursor_engine ttce_checker u_ttce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_cell     (write_cell),
    .cell_char      (cell_char),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .scroll_up      (scroll_up),
    .clear_screen   (clear_screen),
    .new_cursor_row (new_cursor_row),
    .new_cursor_col (new_cursor_col)
);

>>> tb/tb.sv
// self-checking testbench for the terminal text cursor engine: predicts every cursor update
`timescale 1ns / 1ps

module tb;

    import ttce_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;

    class cursor_scoreboard;
        byte_t       rows_reg;
        byte_t       cols_reg;
        byte_t       cur_row;
        byte_t       cur_col;
        result_t     expected_updates[$];
        int unsigned errors;
        int unsigned bytes_seen;
        int unsigned updates_seen;

        function new();
            rows_reg = SCREEN_ROWS_RESET;
            cols_reg = SCREEN_COLS_RESET;
            cur_row = '0;
            cur_col = '0;
            errors = 0;
            bytes_seen = 0;
            updates_seen = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, byte_t value);
            if (idx == REG_SCREEN_ROWS)
                rows_reg = value;
            else if (idx == REG_SCREEN_COLS)
                cols_reg = value;
        endfunction

        function int unsigned pending();
            return expected_updates.size();
        endfunction

        function void accept_byte(byte_t ch);
            byte_t   last_row;
            byte_t   last_col;
            result_t upd;
            last_row = (rows_reg == 8'd0) ? 8'd0 : rows_reg - 8'd1;
            last_col = (cols_reg == 8'd0) ? 8'd0 : cols_reg - 8'd1;
            bytes_seen++;
            if (cur_row > last_row)
                cur_row = last_row;
            if (cur_col > last_col)
                cur_col = last_col;
            if (ch == CH_NUL || ch == CH_IGNORE_HI)
                return;
            upd = '0;
            case (ch)
                CH_FORMFEED:
                begin
                    upd.clear_screen = 1'b1;
                    cur_row = '0;
                    cur_col = '0;
                end
                CH_BACKSPACE:
                begin
                    if (cur_col != 8'd0)
                        cur_col = cur_col - 8'd1;
                end
                CH_RETURN:
                begin
                    cur_col = '0;
                end
                CH_LINEFEED:
                begin
                    if (cur_row == last_row)
                        upd.scroll_up = 1'b1;
                    else
                        cur_row = cur_row + 8'd1;
                end
                default:
                begin
                    upd.write_cell = 1'b1;
                    upd.cell_char = ch;
                    upd.cell_row = cur_row;
                    upd.cell_col = cur_col;
                    if (cur_col == last_col)
                    begin
                        cur_col = '0;
                        if (cur_row == last_row)
                            upd.scroll_up = 1'b1;
                        else
                            cur_row = cur_row + 8'd1;
                    end
                    else
                    begin
                        cur_col = cur_col + 8'd1;
                    end
                end
            endcase
            upd.new_cursor_row = cur_row;
            upd.new_cursor_col = cur_col;
            expected_updates.push_back(upd);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_update(result_t got);
            result_t want;
            updates_seen++;
            if (expected_updates.size() == 0)
            begin
                $error("cursor update arrived with nothing expected");
                errors++;
                return;
            end
            want = expected_updates.pop_front();
            compare("write_cell", {7'd0, want.write_cell}, {7'd0, got.write_cell});
            compare("cell_char", want.cell_char, got.cell_char);
            compare("cell_row", want.cell_row, got.cell_row);
            compare("cell_col", want.cell_col, got.cell_col);
            compare("scroll_up", {7'd0, want.scroll_up}, {7'd0, got.scroll_up});
            compare("clear_screen", {7'd0, want.clear_screen}, {7'd0, got.clear_screen});
            compare("new_cursor_row", want.new_cursor_row, got.new_cursor_row);
            compare("new_cursor_col", want.new_cursor_col, got.new_cursor_col);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    byte_t                  rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic                   write_cell;
    byte_t                  cell_char;
    byte_t                  cell_row;
    byte_t                  cell_col;
    logic                   scroll_up;
    logic                   clear_screen;
    byte_t                  new_cursor_row;
    byte_t                  new_cursor_col;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    byte_t                  cfg_data;

    cursor_scoreboard sb;
    int unsigned      quiet_cycles = 0;
    int unsigned      sizes_tried = 0;
    bit               hold_request = 1'b0;

    terminal_text_cursor_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .write_cell     (write_cell),
        .cell_char      (cell_char),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .scroll_up      (scroll_up),
        .clear_screen   (clear_screen),
        .new_cursor_row (new_cursor_row),
        .new_cursor_col (new_cursor_col),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid && !out_stall)
                sb.check_update(result_t'({write_cell, cell_char, cell_row, cell_col,
                                           scroll_up, clear_screen,
                                           new_cursor_row, new_cursor_col}));
            if (in_valid && !in_stall)
                sb.accept_byte(rx_byte);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    initial
    begin
        do @(posedge clk); while (!rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL terminal_text_cursor_engine");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int unsigned len;
        int unsigned style;
        out_stall = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                len = $urandom_range(1, 40);
                style = $urandom_range(0, 3);
                repeat (len)
                begin
                    case (style)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= $urandom_range(0, 1);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_byte(input byte_t b);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            rx_byte <= byte_t'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input byte_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // wait for every update to drain, then resize the screen
    task automatic set_screen(input byte_t rows, input byte_t cols);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(REG_SCREEN_ROWS, rows);
        write_reg(REG_SCREEN_COLS, cols);
        cfg_valid <= 1'b0;
        sizes_tried++;
    endtask

    function automatic byte_t pick_byte(bit text_run);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (text_run)
        begin
            if (roll < 97)
                return byte_t'($urandom_range(32, 126));
            return (roll < 99) ? CH_BACKSPACE : CH_LINEFEED;
        end
        if (roll < 2)
            return CH_FORMFEED;
        if (roll < 10)
            return CH_LINEFEED;
        if (roll < 15)
            return CH_RETURN;
        if (roll < 20)
            return CH_BACKSPACE;
        if (roll < 22)
            return CH_NUL;
        if (roll < 24)
            return CH_IGNORE_HI;
        if (roll < 38)
            return byte_t'($urandom_range(0, 255));
        return byte_t'($urandom_range(32, 126));
    endfunction

    function automatic byte_t pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd0;
        if (roll == 1)
            return 8'd255;
        return byte_t'($urandom_range(1, 12));
    endfunction

    task automatic run_phase(input byte_t rows, input byte_t cols, input int unsigned count,
                             input bit text_run);
        int unsigned sent;
        int unsigned burst;
        int unsigned roll;
        byte_t       b;
        set_screen(rows, cols);
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                b = pick_byte(text_run);
                send_byte(b);
                if (b != CH_NUL && b != CH_IGNORE_HI)
                    sent++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 35)
                pause_sender(0);
            else if (roll < 90)
                pause_sender($urandom_range(1, 4));
            else
                pause_sender($urandom_range(5, 20));
        end
    endtask

    initial
    begin
        byte_t reset_bytes[];
        byte_t tiny_bytes[];
        int    k;

        reset_bytes = '{CH_NUL, CH_IGNORE_HI, CH_BACKSPACE, 8'h41, CH_BACKSPACE,
                        8'h42, 8'h43, CH_RETURN, CH_LINEFEED, 8'd1, 8'd254,
                        8'd128, 8'd127, CH_FORMFEED, CH_LINEFEED, CH_LINEFEED};
        tiny_bytes = '{8'h61, 8'h62, 8'h63, 8'h64, CH_LINEFEED, CH_RETURN,
                       CH_BACKSPACE, CH_FORMFEED};
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_bytes[i])
            send_byte(reset_bytes[i]);
        set_screen(8'd2, 8'd2);
        foreach (tiny_bytes[i])
            send_byte(tiny_bytes[i]);

        run_phase(8'd2, 8'd3, 60, 1'b0);
        run_phase(8'd1, 8'd1, 40, 1'b0);
        run_phase(8'd0, 8'd0, 30, 1'b0);
        run_phase(8'd1, 8'd255, 300, 1'b1);
        run_phase(8'd255, 8'd1, 60, 1'b0);
        run_phase(8'd255, 8'd255, 60, 1'b1);
        hold_request = 1'b1;
        run_phase(8'd4, 8'd6, 80, 1'b0);
        for (k = 0; k < 8; k++)
            run_phase(pick_size(), pick_size(), 40, $urandom_range(0, 3) == 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("checked %0d cursor updates from %0d accepted bytes", sb.updates_seen,
                 sb.bytes_seen);
        $display("screen sizes tried: %0d, from zero through 255 rows and columns", sizes_tried);
        if (sb.errors == 0)
            $display("PASS terminal_text_cursor_engine");
        else
            $display("FAIL terminal_text_cursor_engine");
        $finish;
    end

endmodule

>>> terminal_text_cursor_engine.f
sv/ttce_pkg.sv
sv/ttce_cursor_logic.sv
sv/terminal_text_cursor_engine.sv
sv/ttce_checker.sv
tb/tb.sv
